// File: design/aesc_pkg.sv
// Shared types, tables and byte-level functions for the AES block cipher.
package aesc_pkg;

    localparam int NUM_RK   = 15;
    localparam int MAX_RND  = 14;
    localparam int CFG_IDX_W = 3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_KEY_SIZE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_0_7  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_8_15 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_16_23 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_24_31 = 3'd4;

    // Key size codes.
    localparam logic [1:0] KS_128 = 2'd0;
    localparam logic [1:0] KS_192 = 2'd1;
    localparam logic [1:0] KS_256 = 2'd2;

    localparam logic [7:0] GF_POLY = 8'h1b;
    localparam logic [7:0] RCON_INIT = 8'h01;

    typedef logic [127:0] t_block;
    typedef logic [NUM_RK-1:0][127:0] t_rk_arr;

    // Per-stage round control.
    typedef struct packed {
        logic act;
        logic last;
    } t_round_ctl;

    localparam logic [7:0] FWD_BOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    localparam logic [7:0] INV_BOX [256] = '{
        8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
        8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
        8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
        8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
        8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
        8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
        8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
        8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
        8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
        8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
        8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
        8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
        8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
        8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
        8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
        8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
    };

    // Multiply by two in GF(2^8).
    function automatic logic [7:0] xtime(input logic [7:0] a);
        xtime = {a[6:0], 1'b0} ^ (a[7] ? GF_POLY : 8'h00);
    endfunction

    function automatic logic [31:0] sub_word(input logic [31:0] w);
        sub_word = {FWD_BOX[w[31:24]], FWD_BOX[w[23:16]], FWD_BOX[w[15:8]], FWD_BOX[w[7:0]]};
    endfunction

    // Byte n of a block; byte 0 is the most significant.
    function automatic logic [7:0] get_byte(input t_block s, input int n);
        get_byte = s[127-8*n -: 8];
    endfunction

    function automatic t_block sub_fwd(input t_block s);
        t_block t;
        for (int i = 0; i < 16; i++) t[127-8*i -: 8] = FWD_BOX[get_byte(s, i)];
        sub_fwd = t;
    endfunction

    function automatic t_block sub_inv(input t_block s);
        t_block t;
        for (int i = 0; i < 16; i++) t[127-8*i -: 8] = INV_BOX[get_byte(s, i)];
        sub_inv = t;
    endfunction

    function automatic t_block shift_fwd(input t_block s);
        t_block t;
        for (int c = 0; c < 4; c++)
            for (int r = 0; r < 4; r++)
                t[127-8*(4*c+r) -: 8] = get_byte(s, 4*((c+r)%4)+r);
        shift_fwd = t;
    endfunction

    function automatic t_block shift_inv(input t_block s);
        t_block t;
        for (int c = 0; c < 4; c++)
            for (int r = 0; r < 4; r++)
                t[127-8*(4*((c+r)%4)+r) -: 8] = get_byte(s, 4*c+r);
        shift_inv = t;
    endfunction

    // Forward column mix: coefficients 2, 3, 1, 1.
    function automatic t_block mix_fwd(input t_block s);
        t_block t;
        logic [7:0] a0, a1, a2, a3;
        for (int c = 0; c < 4; c++)
            for (int r = 0; r < 4; r++) begin
                a0 = get_byte(s, 4*c + r);
                a1 = get_byte(s, 4*c + (r+1)%4);
                a2 = get_byte(s, 4*c + (r+2)%4);
                a3 = get_byte(s, 4*c + (r+3)%4);
                t[127-8*(4*c+r) -: 8] = xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3;
            end
        mix_fwd = t;
    endfunction

    // Inverse column mix: coefficients 0x0e, 0x0b, 0x0d, 0x09.
    function automatic t_block mix_inv(input t_block s);
        t_block t;
        logic [7:0] a [4];
        logic [7:0] x2 [4];
        logic [7:0] x4 [4];
        logic [7:0] x8 [4];
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                a[r]  = get_byte(s, 4*c + r);
                x2[r] = xtime(a[r]);
                x4[r] = xtime(x2[r]);
                x8[r] = xtime(x4[r]);
            end
            for (int r = 0; r < 4; r++)
                t[127-8*(4*c+r) -: 8] =
                    (x8[r] ^ x4[r] ^ x2[r]) ^
                    (x8[(r+1)%4] ^ x2[(r+1)%4] ^ a[(r+1)%4]) ^
                    (x8[(r+2)%4] ^ x4[(r+2)%4] ^ a[(r+2)%4]) ^
                    (x8[(r+3)%4] ^ a[(r+3)%4]);
        end
        mix_inv = t;
    endfunction

endpackage

// File: design/aesc_if.sv
// Valid/ready channel interfaces for blocks in and results out.
interface aesc_in_if;
    logic        valid;
    logic        ready;
    logic        func;
    logic [63:0] block_hi;
    logic [63:0] block_lo;
    modport source (output valid, func, block_hi, block_lo, input ready);
    modport sink   (input valid, func, block_hi, block_lo, output ready);
endinterface

interface aesc_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] result_hi;
    logic [63:0] result_lo;
    modport source (output valid, result_hi, result_lo, input ready);
    modport sink   (input valid, result_hi, result_lo, output ready);
endinterface

// File: design/aes_block_cipher.sv
// AES-128/192/256 encrypt/decrypt top level with a fifteen-stage round pipeline.
//
//  Channel   Dir  Handshake        Payload
//  i_in      in   valid/ready      func, block_hi, block_lo
//  o_out     out  valid/ready      result_hi, result_lo
//  i_cfg_*   in   write enable     index, 64-bit data
//
// One block per cycle is accepted unless the key schedule is busy or the output stalls.
// All three key sizes run through the same 14 round stages; short keys pass the tail.
// After reset and after every configuration write the key schedule is rebuilt one word
// per cycle, and input is held off until it is done.
// A stall at the output freezes the whole pipeline; the last stage is the output register.
module aes_block_cipher (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    aesc_in_if.sink                         i_in,
    aesc_out_if.source                      o_out,
    input  logic                            i_cfg_we,
    input  logic [aesc_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [63:0]                     i_cfg_data
);
    import aesc_pkg::*;

    logic [1:0]       r_key_size;
    logic [3:0][63:0] r_key;
    t_rk_arr          rk;
    logic             busy, en;
    t_block           rk_last;

    logic   [MAX_RND:0] v;
    logic   [MAX_RND:0] f;
    t_block             s [MAX_RND+1];

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_size <= '0;
            r_key      <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_KEY_SIZE:  r_key_size <= i_cfg_data[1:0];
                REG_KEY_0_7:   r_key[0]   <= i_cfg_data;
                REG_KEY_8_15:  r_key[1]   <= i_cfg_data;
                REG_KEY_16_23: r_key[2]   <= i_cfg_data;
                REG_KEY_24_31: r_key[3]   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    aesc_key_expand u_key (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cfg_we),
        .i_key_size (r_key_size),
        .i_key      (r_key),
        .o_rk       (rk),
        .o_busy     (busy)
    );

    assign en         = !o_out.valid || o_out.ready;
    assign i_in.ready = en && !busy;

    // Last round key for the selected size.
    always_comb begin
        case (r_key_size)
            KS_128:  rk_last = rk[10];
            KS_192:  rk_last = rk[12];
            default: rk_last = rk[14];
        endcase
    end

    // Stage zero: initial key addition.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            v[0] <= 1'b0;
        end else if (en) begin
            v[0] <= i_in.valid && !busy;
        end
        if (en) begin
            f[0] <= i_in.func;
            s[0] <= {i_in.block_hi, i_in.block_lo} ^ (i_in.func ? rk_last : rk[0]);
        end
    end

    // Round stages.
    for (genvar k = 1; k <= MAX_RND; k++) begin : g_rnd
        localparam int D10 = (10 - k > 0) ? 10 - k : 0;
        localparam int D12 = (12 - k > 0) ? 12 - k : 0;
        localparam int D14 = (14 - k > 0) ? 14 - k : 0;
        t_round_ctl ctl;
        t_block     key;

        always_comb begin
            case (r_key_size)
                KS_128: begin
                    ctl.act  = (k <= 10);
                    ctl.last = (k == 10);
                    key      = rk[D10];
                end
                KS_192: begin
                    ctl.act  = (k <= 12);
                    ctl.last = (k == 12);
                    key      = rk[D12];
                end
                default: begin
                    ctl.act  = 1'b1;
                    ctl.last = (k == 14);
                    key      = rk[D14];
                end
            endcase
            if (!f[k-1])
                key = rk[k];
        end

        aesc_round u_round (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (v[k-1]),
            .i_func  (f[k-1]),
            .i_state (s[k-1]),
            .i_key   (key),
            .i_ctl   (ctl),
            .o_valid (v[k]),
            .o_func  (f[k]),
            .o_state (s[k])
        );
    end

    assign o_out.valid     = v[MAX_RND];
    assign o_out.result_hi = s[MAX_RND][127:64];
    assign o_out.result_lo = s[MAX_RND][63:0];

    // A configuration write always restarts the key schedule.
    a_cfg_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_we |=> busy) else $error("key schedule not restarted");

    // No transaction is taken while the schedule is being rebuilt.
    a_busy_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |-> !i_in.ready) else $error("input accepted during key expansion");

    // A stalled output freezes the stage feeding it.
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.ready) |=> (v[MAX_RND-1] == $past(v[MAX_RND-1])))
        else $error("pipeline moved during stall");
endmodule

// File: design/aesc_key_expand.sv
// Sequential key schedule: one round-key word per cycle into a round-key register file.
module aesc_key_expand (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [1:0]            i_key_size,
    input  logic [3:0][63:0]      i_key,
    output aesc_pkg::t_rk_arr     o_rk,
    output logic                  o_busy
);
    import aesc_pkg::*;

    logic [7:0][31:0] r_win;
    logic [5:0]       r_cnt;
    logic [2:0]       r_mod;
    logic [7:0]       r_rc;
    logic             r_busy;
    t_rk_arr          r_rk;

    logic [3:0]  nk;
    logic [5:0]  last_cnt;
    logic [31:0] key_w, prev, far, tmp, n_word;
    logic [63:0] key_pair;

    // Key length in words and index of the final schedule word.
    always_comb begin
        case (i_key_size)
            KS_128:  begin nk = 4'd4; last_cnt = 6'd43; far = r_win[4]; end
            KS_192:  begin nk = 4'd6; last_cnt = 6'd51; far = r_win[2]; end
            default: begin nk = 4'd8; last_cnt = 6'd59; far = r_win[0]; end
        endcase
    end

    // Next schedule word.
    always_comb begin
        key_pair = i_key[r_cnt[2:1]];
        key_w    = r_cnt[0] ? key_pair[31:0] : key_pair[63:32];
        prev     = r_win[7];
        tmp      = prev;
        if (r_mod == 3'd0)
            tmp = sub_word({prev[23:0], prev[31:24]}) ^ {r_rc, 24'd0};
        else if (nk == 4'd8 && r_mod == 3'd4)
            tmp = sub_word(prev);
        n_word = ({2'd0, r_cnt} < {4'd0, nk}) ? key_w : (far ^ tmp);
    end

    // Expansion sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
            r_mod  <= '0;
            r_rc   <= RCON_INIT;
        end else if (r_busy) begin
            r_win <= {n_word, r_win[7:1]};
            r_rk[r_cnt[5:2]][127-32*r_cnt[1:0] -: 32] <= n_word;
            if ({2'd0, r_cnt} >= {4'd0, nk} && r_mod == 3'd0)
                r_rc <= xtime(r_rc);
            r_mod <= ({1'b0, r_mod} == nk - 4'd1) ? 3'd0 : r_mod + 3'd1;
            r_cnt <= r_cnt + 6'd1;
            if (r_cnt == last_cnt)
                r_busy <= 1'b0;
        end
    end

    assign o_rk   = r_rk;
    assign o_busy = r_busy;
endmodule

// File: design/aesc_round.sv
// One registered cipher round stage; encrypts or decrypts per transaction.
module aesc_round (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_en,
    input  logic                   i_valid,
    input  logic                   i_func,
    input  aesc_pkg::t_block       i_state,
    input  aesc_pkg::t_block       i_key,
    input  aesc_pkg::t_round_ctl   i_ctl,
    output logic                   o_valid,
    output logic                   o_func,
    output aesc_pkg::t_block       o_state
);
    import aesc_pkg::*;

    logic   r_valid, r_func;
    t_block r_state;
    t_block e_sh, e_mx, d_add, n_state;

    // Forward round, inverse round in standard inverse-cipher order, or pass-through when inactive.
    always_comb begin
        e_sh  = shift_fwd(sub_fwd(i_state));
        e_mx  = i_ctl.last ? e_sh : mix_fwd(e_sh);
        d_add = sub_inv(shift_inv(i_state)) ^ i_key;
        if (!i_ctl.act)
            n_state = i_state;
        else if (i_func)
            n_state = i_ctl.last ? d_add : mix_inv(d_add);
        else
            n_state = e_mx ^ i_key;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
        if (i_en) begin
            r_func  <= i_func;
            r_state <= n_state;
        end
    end

    assign o_valid = r_valid;
    assign o_func  = r_func;
    assign o_state = r_state;
endmodule

// File: dv/aes_block_cipher_checker.sv
// Checker for the AES block cipher: predicts every result and compares it with the block.
module aes_block_cipher_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    aesc_in_if.sink                        i_in,
    aesc_out_if.sink                       i_out,
    input  logic                           i_cfg_we,
    input  logic [aesc_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [63:0]                    i_cfg_data,
    output int                             o_fail_count,
    output int                             o_pending
);
    import aesc_pkg::*;

    // Shadow copy of the configuration registers.
    logic [1:0]  key_size_q;
    logic [63:0] key_reg [4];

    // Ciphertext or plaintext blocks still owed by the block.
    logic [127:0] cipher_queue [$];

    // Multiply two field elements by shift and add.
    function automatic logic [7:0] gf_times(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] acc;
        acc = 8'h00;
        for (int k = 0; k < 8; k++) begin
            if (b[k]) acc ^= a;
            a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
        end
        return acc;
    endfunction

    // Full encryption or decryption of one block under the current shadow key.
    function automatic logic [127:0] cipher_block(input logic decrypt, input logic [127:0] blk);
        logic [31:0] w [60];
        logic [7:0]  st [16];
        logic [7:0]  tmp [16];
        logic [7:0]  col [4];
        logic [7:0]  cf [4];
        logic [31:0] t;
        logic [7:0]  rc;
        logic [127:0] res;
        int nk, nr, rnd;
        nk = (key_size_q == KS_128) ? 4 : (key_size_q == KS_192) ? 6 : 8;
        nr = nk + 6;
        rc = 8'h01;
        for (int i = 0; i < nk; i++)
            w[i] = (i % 2 == 0) ? key_reg[i/2][63:32] : key_reg[i/2][31:0];
        for (int i = nk; i < 4*(nr+1); i++) begin
            t = w[i-1];
            if (i % nk == 0) begin
                t = {t[23:0], t[31:24]};
                t = {FWD_BOX[t[31:24]], FWD_BOX[t[23:16]], FWD_BOX[t[15:8]], FWD_BOX[t[7:0]]}
                    ^ {rc, 24'h0};
                rc = gf_times(rc, 8'h02);
            end else if (nk > 6 && i % nk == 4) begin
                t = {FWD_BOX[t[31:24]], FWD_BOX[t[23:16]], FWD_BOX[t[15:8]], FWD_BOX[t[7:0]]};
            end
            w[i] = w[i-nk] ^ t;
        end
        for (int i = 0; i < 16; i++) st[i] = blk[127-8*i -: 8];
        if (decrypt) cf = '{8'h0e, 8'h0b, 8'h0d, 8'h09};
        else cf = '{8'h02, 8'h03, 8'h01, 8'h01};
        // Steps are applied in a fixed per-round order; s counts rounds in processing order.
        for (int s = 0; s <= nr; s++) begin
            rnd = decrypt ? nr - s : s;
            if (s > 0) begin
                if (decrypt) begin
                    for (int c = 0; c < 4; c++)
                        for (int r = 0; r < 4; r++) tmp[4*((c+r)%4)+r] = st[4*c+r];
                    for (int i = 0; i < 16; i++) st[i] = INV_BOX[tmp[i]];
                end else begin
                    for (int i = 0; i < 16; i++) tmp[i] = FWD_BOX[st[i]];
                    for (int c = 0; c < 4; c++)
                        for (int r = 0; r < 4; r++) st[4*c+r] = tmp[4*((c+r)%4)+r];
                end
            end
            // Encryption mixes before the round key, decryption after it.
            if (!decrypt && s > 0 && s < nr) begin
                for (int c = 0; c < 4; c++) begin
                    for (int r = 0; r < 4; r++) col[r] = st[4*c+r];
                    for (int r = 0; r < 4; r++)
                        st[4*c+r] = gf_times(cf[0], col[r]) ^ gf_times(cf[1], col[(r+1)%4])
                                  ^ gf_times(cf[2], col[(r+2)%4]) ^ gf_times(cf[3], col[(r+3)%4]);
                end
            end
            for (int c = 0; c < 4; c++)
                for (int r = 0; r < 4; r++) st[4*c+r] ^= w[4*rnd+c][31-8*r -: 8];
            if (decrypt && s > 0 && s < nr) begin
                for (int c = 0; c < 4; c++) begin
                    for (int r = 0; r < 4; r++) col[r] = st[4*c+r];
                    for (int r = 0; r < 4; r++)
                        st[4*c+r] = gf_times(cf[0], col[r]) ^ gf_times(cf[1], col[(r+1)%4])
                                  ^ gf_times(cf[2], col[(r+2)%4]) ^ gf_times(cf[3], col[(r+3)%4]);
                end
            end
        end
        for (int i = 0; i < 16; i++) res[127-8*i -: 8] = st[i];
        return res;
    endfunction

    assign o_pending = cipher_queue.size();

    // Track register writes, predict accepted blocks and compare results.
    always @(posedge i_clk) begin
        logic [127:0] want;
        if (!i_rst_n) begin
            key_size_q = 2'd0;
            for (int i = 0; i < 4; i++) key_reg[i] = 64'h0;
            o_fail_count <= 0;
        end else begin
            if (i_out.valid && i_out.ready) begin
                if (cipher_queue.size() == 0) begin
                    $display("%0t: unexpected result %h_%h", $realtime,
                             i_out.result_hi, i_out.result_lo);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = cipher_queue.pop_front();
                    if (want[127:64] !== i_out.result_hi || want[63:0] !== i_out.result_lo) begin
                        $display("%0t: result mismatch expected %h_%h actual %h_%h", $realtime,
                                 want[127:64], want[63:0], i_out.result_hi, i_out.result_lo);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
            if (i_in.valid && i_in.ready)
                cipher_queue.push_back(cipher_block(i_in.func, {i_in.block_hi, i_in.block_lo}));
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_KEY_SIZE:  key_size_q = i_cfg_data[1:0];
                    REG_KEY_0_7:   key_reg[0] = i_cfg_data;
                    REG_KEY_8_15:  key_reg[1] = i_cfg_data;
                    REG_KEY_16_23: key_reg[2] = i_cfg_data;
                    REG_KEY_24_31: key_reg[3] = i_cfg_data;
                    default: ;
                endcase
            end
        end
    end
endmodule

// File: dv/aes_block_cipher_test.sv
// Testbench top for the AES block cipher: stimulus, key phases and the verdict.
module aes_block_cipher_test;
    import aesc_pkg::*;

    localparam int IDLE_LIMIT = 4000;
    localparam int RANDOM_BLOCKS = 1350;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic [63:0]          cfg_data;
    int                   fail_count;
    int                   pending;
    int                   idle_cycles;
    bit                   sending_done;
    bit                   r_in_fire;
    bit                   r_out_fire;
    int                   r_out_wait;

    aesc_in_if  in_ch ();
    aesc_out_if out_ch ();

    aes_block_cipher dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in(in_ch.sink), .o_out(out_ch.source),
        .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx), .i_cfg_data(cfg_data)
    );

    aes_block_cipher_checker checker_inst (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in(in_ch.sink), .i_out(out_ch.sink),
        .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx), .i_cfg_data(cfg_data),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    always begin
        i_clk = 1'b1;
        #6;
        i_clk = 1'b0;
        #6;
    end

    // Transactions seen at the last rising edge.
    always @(posedge i_clk) begin
        r_in_fire  <= in_ch.valid && in_ch.ready;
        r_out_fire <= out_ch.valid && out_ch.ready;
    end

    // Write one configuration register in a single cycle.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] data);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(negedge i_clk);
        cfg_we   <= 1'b0;
    endtask

    // Send one block after a random gap and wait for its transaction.
    task automatic send_block(input logic decrypt, input logic [63:0] hi, input logic [63:0] lo);
        int gap;
        gap = (($urandom % 4) == 0) ? 0 : $urandom_range(0, 17);
        if (gap != 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_ch.valid    <= 1'b1;
        in_ch.func     <= decrypt;
        in_ch.block_hi <= hi;
        in_ch.block_lo <= lo;
        do @(negedge i_clk); while (!r_in_fire);
    endtask

    // Let all results drain, then allow the pipeline to empty before a key change.
    task automatic drain_pipeline();
        in_ch.valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
    endtask

    task automatic load_key(input logic [1:0] ks, input logic [63:0] k0, input logic [63:0] k1,
                            input logic [63:0] k2, input logic [63:0] k3);
        drain_pipeline();
        write_reg(REG_KEY_SIZE, {62'h0, ks});
        write_reg(REG_KEY_0_7, k0);
        write_reg(REG_KEY_8_15, k1);
        write_reg(REG_KEY_16_23, k2);
        write_reg(REG_KEY_24_31, k3);
    endtask

    // Output stall: each result waits a random number of cycles, sometimes none.
    always @(negedge i_clk) begin
        int w;
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
            r_out_wait   <= $urandom_range(0, 17);
        end else if (r_out_fire) begin
            w = (($urandom % 3) == 0) ? 0 : $urandom_range(0, 17);
            r_out_wait   <= w;
            out_ch.ready <= (w == 0);
        end else if (r_out_wait != 0) begin
            r_out_wait   <= r_out_wait - 1;
            out_ch.ready <= (r_out_wait == 1);
        end else begin
            out_ch.ready <= 1'b1;
        end
    end

    // Watchdog over cycles without any transaction.
    always @(posedge i_clk) begin
        if (!i_rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
            || (sending_done && pending == 0))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin
        logic [63:0] kw [4];
        logic [1:0]  ks;
        sending_done   = 1'b0;
        i_rst_n        = 1'b0;
        cfg_we         = 1'b0;
        cfg_idx        = '0;
        cfg_data       = '0;
        in_ch.valid    = 1'b0;
        in_ch.func     = 1'b0;
        in_ch.block_hi = '0;
        in_ch.block_lo = '0;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset key, then the standard known-answer keys for each key size.
        send_block(1'b0, 64'h0, 64'h0);
        send_block(1'b1, '1, '1);
        load_key(KS_128, 64'h0001020304050607, 64'h08090a0b0c0d0e0f, '1, '1);
        send_block(1'b0, 64'h0011223344556677, 64'h8899aabbccddeeff);
        send_block(1'b1, 64'h69c4e0d86a7b0430, 64'hd8cdb78070b4c55a);
        load_key(KS_192, 64'h0001020304050607, 64'h08090a0b0c0d0e0f,
                 64'h1011121314151617, '1);
        send_block(1'b0, 64'h0011223344556677, 64'h8899aabbccddeeff);
        send_block(1'b1, 64'hdda97ca4864cdfe0, 64'h6eaf70a0ec0d7191);
        load_key(KS_256, 64'h0001020304050607, 64'h08090a0b0c0d0e0f,
                 64'h1011121314151617, 64'h18191a1b1c1d1e1f);
        send_block(1'b0, 64'h0011223344556677, 64'h8899aabbccddeeff);
        send_block(1'b1, 64'h8ea2b7ca516745bf, 64'heafc49904b496089);
        // Unused size code behaves as the largest key; a write past the last register is dropped.
        load_key(2'd3, '1, '1, '1, '1);
        write_reg(3'd5, 64'h0123456789abcdef);
        write_reg(3'd7, '1);
        send_block(1'b0, '1, '1);
        send_block(1'b1, 64'h0, 64'h0);
        send_block(1'b0, 64'h8000000000000000, 64'h1);

        // Random phases, each under a freshly loaded key and size.
        for (int ph = 0; ph < 9; ph++) begin
            for (int i = 0; i < 4; i++) kw[i] = {$urandom, $urandom};
            ks = (ph < 3) ? ph[1:0] : 2'($urandom_range(0, 3));
            if (ph == 8) begin
                kw[0] = '1;
                kw[1] = '0;
            end
            load_key(ks, kw[0], kw[1], kw[2], kw[3]);
            for (int i = 0; i < RANDOM_BLOCKS / 9; i++)
                send_block(1'($urandom), {$urandom, $urandom}, {$urandom, $urandom});
        end

        sending_done = 1'b1;
        drain_pipeline();
        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule

// File: aes_block_cipher.f
design/aesc_pkg.sv
design/aesc_if.sv
design/aesc_key_expand.sv
design/aesc_round.sv
design/aes_block_cipher.sv
dv/aes_block_cipher_checker.sv
dv/aes_block_cipher_test.sv
